/* src/mrm_pkg.sv */
package mrm_pkg;

	localparam int MAX_FRAME_DEF = 256;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] FN_READ = 8'h03;
	localparam logic [7:0] FN_WRITE = 8'h06;
	localparam logic [7:0] READ_COUNT = 8'h02;
	localparam logic [15:0] READ_QTY = 16'h0001;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_HEADER = 3'd2;
	localparam logic [2:0] ST_CRC = 3'd3;
	localparam logic [2:0] ST_COUNT = 3'd4;
	localparam logic [2:0] ST_ECHO = 3'd5;
	localparam logic [2:0] ST_NONE = 3'd6;

	localparam logic KIND_TX = 1'b0;
	localparam logic KIND_RESULT = 1'b1;

	localparam logic [1:0] ACT_READ = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_BYTE = 2'd2;
	localparam logic [1:0] ACT_END = 2'd3;

	typedef enum logic [1:0] {
		OP_READ,
		OP_WRITE,
		OP_BYTE,
		OP_END
	} op_code_t;

	typedef struct packed {
		op_code_t code;
		logic [7:0] fn_code;
		logic [15:0] target_reg;
		logic [15:0] data_word;
		logic [7:0] rx_byte;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t item;
	} q_head_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* src/mrm_ifs.sv */
interface mrm_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [15:0] target_reg;
	logic [15:0] write_value;
	logic [7:0] rx_byte;

	modport source (output valid, action, target_reg, write_value, rx_byte, input ready);
	modport sink (input valid, action, target_reg, write_value, rx_byte, output ready);
endinterface

interface mrm_rsp_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] tx_byte;
	logic last;
	logic [2:0] status;
	logic [15:0] read_value;

	modport source (output valid, kind, tx_byte, last, status, read_value, input ready);
	modport sink (input valid, kind, tx_byte, last, status, read_value, output ready);
endinterface

interface mrm_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/mrm_front.sv */
module mrm_front (
	mrm_cmd_if.sink cmd,
	input logic full,
	output logic push,
	output mrm_pkg::op_t item
);
	import mrm_pkg::*;

	assign cmd.ready = !full;
	assign push = cmd.valid && !full;

	always_comb begin
		item = '0;
		item.target_reg = cmd.target_reg;
		item.rx_byte = cmd.rx_byte;
		unique case (cmd.action)
			ACT_READ: begin
				item.code = OP_READ;
				item.fn_code = FN_READ;
				item.data_word = READ_QTY;
			end
			ACT_WRITE: begin
				item.code = OP_WRITE;
				item.fn_code = FN_WRITE;
				item.data_word = cmd.write_value;
			end
			ACT_BYTE: begin
				item.code = OP_BYTE;
			end
			default: begin
				item.code = OP_END;
			end
		endcase
	end

endmodule

/* src/mrm_queue.sv */
module mrm_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mrm_pkg::op_t push_item,
	output logic full,
	output mrm_pkg::q_head_t head,
	input logic pop
);
	import mrm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [CNTW-1:0] FULL_CNT = CNTW'(QUEUE_DEPTH);

	op_t entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic do_pop;

	assign full = count_q == FULL_CNT;
	assign head.valid = count_q != '0;
	assign head.item = entry_q[rd_ptr_q];
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/mrm_back.sv */
module mrm_back #(
	parameter int MAX_FRAME = mrm_pkg::MAX_FRAME_DEF
) (
	input logic clk,
	input logic arst_n,
	input mrm_pkg::q_head_t head,
	output logic pop,
	mrm_cfg_if.sink cfg,
	mrm_rsp_if.source rsp
);
	import mrm_pkg::*;

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam logic [CW-1:0] RX_LIMIT = CW'(MAX_FRAME);

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_READ = 2'd1;
	localparam logic [1:0] PEND_WRITE = 2'd2;

	localparam logic [2:0] TX_CRC_LO = 3'd6;
	localparam logic [2:0] TX_CRC_HI = 3'd7;

	logic [7:0] slave_q;
	logic [7:0] frame_q [8];
	logic [1:0] pend_q;
	logic busy_q;
	logic [2:0] tx_cnt_q;
	logic [15:0] tx_crc_q;
	logic [CW-1:0] rx_cnt_q;
	logic [15:0] rx_crc_q;
	logic [7:0] trail0_q;
	logic [7:0] trail1_q;
	logic hdr_q;
	logic echo_q;
	logic [7:0] cap0_q;
	logic [7:0] cap1_q;
	logic [7:0] cap2_q;

	logic out_valid_q;
	logic out_kind_q;
	logic [7:0] out_tx_q;
	logic out_last_q;
	logic [2:0] out_status_q;
	logic [15:0] out_value_q;

	logic out_free;
	logic [2:0] rd_idx;
	logic [7:0] rd_byte;
	logic [7:0] tx_byte_c;
	logic emit;
	logic is_end;
	logic is_req;
	logic req_pop;
	logic end_pop;
	logic rx_take;
	logic byte_diff;
	logic [2:0] status_c;
	logic [15:0] value_c;

	assign cfg.ready = 1'b1;

	assign out_free = !out_valid_q || rsp.ready;
	assign rd_idx = busy_q ? tx_cnt_q : rx_cnt_q[2:0];
	assign rd_byte = frame_q[rd_idx];
	assign tx_byte_c = (tx_cnt_q == TX_CRC_LO) ? tx_crc_q[7:0] :
		(tx_cnt_q == TX_CRC_HI) ? tx_crc_q[15:8] : rd_byte;
	assign emit = busy_q && out_free;

	assign is_end = head.item.code == OP_END;
	assign is_req = (head.item.code == OP_READ) || (head.item.code == OP_WRITE);
	assign pop = head.valid && !busy_q && (!is_end || out_free);
	assign req_pop = pop && is_req;
	assign end_pop = pop && is_end;
	assign rx_take = pop && (head.item.code == OP_BYTE) && (pend_q != PEND_NONE) &&
		(rx_cnt_q < RX_LIMIT);
	assign byte_diff = head.item.rx_byte != rd_byte;

	always_comb begin
		value_c = '0;
		if (pend_q == PEND_NONE) begin
			status_c = ST_NONE;
		end else if (rx_cnt_q < CW'(6)) begin
			status_c = ST_SHORT;
		end else if (hdr_q) begin
			status_c = ST_HEADER;
		end else if (rx_crc_q != {trail1_q, trail0_q}) begin
			status_c = ST_CRC;
		end else if (pend_q == PEND_READ) begin
			if (cap0_q != READ_COUNT) begin
				status_c = ST_COUNT;
			end else begin
				status_c = ST_OK;
				value_c = {cap1_q, cap2_q};
			end
		end else begin
			status_c = ((rx_cnt_q < CW'(8)) || echo_q) ? ST_ECHO : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			frame_q[0] <= slave_q;
			frame_q[1] <= head.item.fn_code;
			frame_q[2] <= head.item.target_reg[15:8];
			frame_q[3] <= head.item.target_reg[7:0];
			frame_q[4] <= head.item.data_word[15:8];
			frame_q[5] <= head.item.data_word[7:0];
		end else if (emit) begin
			frame_q[tx_cnt_q] <= tx_byte_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= 8'd1;
			pend_q <= PEND_NONE;
			busy_q <= 1'b0;
			tx_cnt_q <= '0;
			tx_crc_q <= CRC_INIT;
			rx_cnt_q <= '0;
			rx_crc_q <= CRC_INIT;
			trail0_q <= '0;
			trail1_q <= '0;
			hdr_q <= 1'b0;
			echo_q <= 1'b0;
			cap0_q <= '0;
			cap1_q <= '0;
			cap2_q <= '0;
		end else begin
			if (cfg.valid) begin
				slave_q <= cfg.data;
			end
			if (req_pop) begin
				pend_q <= (head.item.code == OP_READ) ? PEND_READ : PEND_WRITE;
				busy_q <= 1'b1;
				tx_cnt_q <= '0;
				tx_crc_q <= CRC_INIT;
				rx_cnt_q <= '0;
				rx_crc_q <= CRC_INIT;
				trail0_q <= '0;
				trail1_q <= '0;
				hdr_q <= 1'b0;
				echo_q <= 1'b0;
				cap0_q <= '0;
				cap1_q <= '0;
				cap2_q <= '0;
			end
			if (emit) begin
				tx_cnt_q <= tx_cnt_q + 1'b1;
				if (tx_cnt_q < TX_CRC_LO) begin
					tx_crc_q <= crc_feed(tx_crc_q, rd_byte);
				end
				if (tx_cnt_q == TX_CRC_HI) begin
					busy_q <= 1'b0;
				end
			end
			if (end_pop) begin
				pend_q <= PEND_NONE;
			end
			if (rx_take) begin
				if ((rx_cnt_q < CW'(2)) && byte_diff) begin
					hdr_q <= 1'b1;
				end
				if ((rx_cnt_q < CW'(8)) && byte_diff) begin
					echo_q <= 1'b1;
				end
				if (rx_cnt_q == CW'(2)) begin
					cap0_q <= head.item.rx_byte;
				end
				if (rx_cnt_q == CW'(3)) begin
					cap1_q <= head.item.rx_byte;
				end
				if (rx_cnt_q == CW'(4)) begin
					cap2_q <= head.item.rx_byte;
				end
				if (rx_cnt_q >= CW'(2)) begin
					rx_crc_q <= crc_feed(rx_crc_q, trail0_q);
				end
				trail0_q <= trail1_q;
				trail1_q <= head.item.rx_byte;
				rx_cnt_q <= rx_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit || end_pop) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= KIND_TX;
			out_tx_q <= tx_byte_c;
			out_last_q <= tx_cnt_q == TX_CRC_HI;
			out_status_q <= ST_OK;
			out_value_q <= '0;
		end else if (end_pop) begin
			out_kind_q <= KIND_RESULT;
			out_tx_q <= '0;
			out_last_q <= 1'b1;
			out_status_q <= status_c;
			out_value_q <= value_c;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.kind = out_kind_q;
	assign rsp.tx_byte = out_tx_q;
	assign rsp.last = out_last_q;
	assign rsp.status = out_status_q;
	assign rsp.read_value = out_value_q;

endmodule

/* src/modbus_rtu_register_master.sv */
// an accepted request is queued, loaded into the frame registers when popped, then sent
// via the output register one byte a cycle while output is not stalled, crc advanced one
// byte per cycle; received byte and end items are popped only while no frame is sending
// a 4-entry queue between front and back accepts input while output stalls, until full
// reset: slave address 1, nothing pending, queue and output register empty
module modbus_rtu_register_master #(
	parameter int MAX_FRAME = mrm_pkg::MAX_FRAME_DEF
) (
	input logic clk,
	input logic arst_n,
	mrm_cmd_if.sink cmd,
	mrm_rsp_if.source rsp,
	mrm_cfg_if.sink cfg
);
	import mrm_pkg::*;

	logic push;
	logic full;
	logic pop;
	op_t push_item;
	q_head_t head;

	mrm_front u_front (
		.cmd (cmd),
		.full (full),
		.push (push),
		.item (push_item)
	);

	mrm_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.push_item (push_item),
		.full (full),
		.head (head),
		.pop (pop)
	);

	mrm_back #(
		.MAX_FRAME (MAX_FRAME)
	) u_back (
		.clk (clk),
		.arst_n (arst_n),
		.head (head),
		.pop (pop),
		.cfg (cfg),
		.rsp (rsp)
	);

endmodule
